@@ design/hdre_pkg.sv @@
// Shared types, constants and helpers of the HID descriptor range extractor.
package hdre_pkg;

  localparam logic [3:0] MAX_NESTING = 4'd10;

  localparam logic [7:0] USAGE_TIP_PRESSURE = 8'h30;
  localparam logic [7:0] USAGE_TILT_X       = 8'h3D;
  localparam logic [7:0] USAGE_TILT_Y       = 8'h3E;

  localparam logic [3:0] TAG_MAIN_DATA_IN    = 4'h8;
  localparam logic [3:0] TAG_MAIN_COLLECTION = 4'hA;
  localparam logic [3:0] TAG_MAIN_END_COLL   = 4'hC;
  localparam logic [3:0] TAG_GLOBAL_USAGE    = 4'h0;
  localparam logic [3:0] TAG_GLOBAL_LOG_MIN  = 4'h1;
  localparam logic [3:0] TAG_GLOBAL_LOG_MAX  = 4'h2;
  localparam logic [3:0] TAG_GLOBAL_REPORT_ID = 4'h8;
  localparam logic [3:0] TAG_LOCAL_USAGE     = 4'h0;

  typedef enum logic [1:0] {
    ITEM_MAIN     = 2'd0,
    ITEM_GLOBAL   = 2'd1,
    ITEM_LOCAL    = 2'd2,
    ITEM_RESERVED = 2'd3
  } item_type_t;

  typedef struct packed {
    logic [7:0]  usage;
    logic [31:0] x_min;
    logic [31:0] x_max;
    logic [31:0] y_min;
    logic [31:0] y_max;
    logic [7:0]  tx_min;
    logic [7:0]  tx_max;
    logic [7:0]  ty_min;
    logic [7:0]  ty_max;
    logic [31:0] p_min;
    logic [31:0] p_max;
  } ranges_t;

  typedef struct packed {
    logic [2:0]  pending;
    logic [7:0]  prefix;
    logic [31:0] shift;
    logic [7:0]  last_pay;
    logic [31:0] glob_min;
    logic [31:0] glob_max;
    logic [31:0] saved_min;
    logic [31:0] saved_max;
    logic [3:0]  depth;
    logic [1:0]  input_idx;
    logic [7:0]  local_usage;
    ranges_t     ranges;
  } parse_state_t;

  // Payload byte count from the two low prefix bits: 0, 1, 2 or 4.
  function automatic logic [2:0] payload_size(input logic [1:0] code);
    logic [2:0] size;
    case (code)
      2'd0:    size = 3'd0;
      2'd1:    size = 3'd1;
      2'd2:    size = 3'd2;
      default: size = 3'd4;
    endcase
    return size;
  endfunction

endpackage

@@ design/hdre_item_step.sv @@
// Next-state logic of the short-item parser for one descriptor byte.
module hdre_item_step (
  input  hdre_pkg::parse_state_t st,
  input  logic [7:0]             desc_byte,
  output hdre_pkg::parse_state_t st_nxt
);
  import hdre_pkg::*;

  logic       done;
  logic [7:0] exec_prefix;
  logic [31:0] payload;
  logic [2:0] cur_size;
  logic [2:0] exec_size;
  logic [2:0] pos_diff;
  logic [3:0] tag;
  item_type_t typ;

  always_comb begin
    st_nxt      = st;
    done        = 1'b0;
    exec_prefix = st.prefix;
    payload     = 32'd0;
    cur_size    = payload_size(st.prefix[1:0]);
    pos_diff    = cur_size - st.pending;

    if (st.pending == 3'd0) begin
      st_nxt.prefix  = desc_byte;
      st_nxt.shift   = 32'd0;
      st_nxt.pending = payload_size(desc_byte[1:0]);
      exec_prefix    = desc_byte;
      done           = (payload_size(desc_byte[1:0]) == 3'd0);
    end else begin
      payload        = st.shift | ({24'd0, desc_byte} << {pos_diff[1:0], 3'b000});
      st_nxt.shift   = payload;
      st_nxt.pending = st.pending - 3'd1;
      if (st.pending == 3'd1) begin
        done = 1'b1;
        if (cur_size == 3'd1) begin
          st_nxt.last_pay = desc_byte;
        end
      end
    end

    tag       = exec_prefix[7:4];
    typ       = item_type_t'(exec_prefix[3:2]);
    exec_size = payload_size(exec_prefix[1:0]);

    if (done) begin
      case (typ)
        ITEM_MAIN: begin
          case (tag)
            TAG_MAIN_DATA_IN: begin
              if (st.input_idx == 2'd0) begin
                if (st.ranges.x_max == 32'd0) begin
                  st_nxt.ranges.x_max = st.glob_max;
                  st_nxt.ranges.x_min = st.glob_min;
                end
              end else if (st.input_idx == 2'd1) begin
                if (st.ranges.y_max == 32'd0) begin
                  st_nxt.ranges.y_max = st.glob_max;
                  st_nxt.ranges.y_min = st.glob_min;
                end
              end else begin
                if (st.local_usage == USAGE_TILT_X && st.ranges.tx_max == 8'd0) begin
                  st_nxt.ranges.tx_max = st.glob_max[7:0];
                  st_nxt.ranges.tx_min = st.glob_min[7:0];
                end
                if (st.local_usage == USAGE_TILT_Y && st.ranges.ty_max == 8'd0) begin
                  st_nxt.ranges.ty_max = st.glob_max[7:0];
                  st_nxt.ranges.ty_min = st.glob_min[7:0];
                end
                if (st.local_usage == USAGE_TIP_PRESSURE && st.ranges.p_max == 32'd0) begin
                  st_nxt.ranges.p_max = st.glob_max;
                  st_nxt.ranges.p_min = st.glob_min;
                end
              end
              if (st.input_idx < 2'd2) begin
                st_nxt.input_idx = st.input_idx + 2'd1;
              end
            end
            TAG_MAIN_COLLECTION: begin
              if (st.depth != MAX_NESTING) begin
                st_nxt.depth     = st.depth + 4'd1;
                st_nxt.saved_min = st.glob_min;
                st_nxt.saved_max = st.glob_max;
              end
            end
            TAG_MAIN_END_COLL: begin
              if (st.depth != 4'd0) begin
                st_nxt.depth    = st.depth - 4'd1;
                st_nxt.glob_min = st.saved_min;
                st_nxt.glob_max = st.saved_max;
              end
            end
            default: begin
            end
          endcase
        end
        ITEM_GLOBAL: begin
          if (tag == TAG_GLOBAL_USAGE && st.ranges.usage == 8'd0) begin
            st_nxt.ranges.usage = st_nxt.last_pay;
          end
          if (tag == TAG_GLOBAL_REPORT_ID) begin
            st_nxt.input_idx = 2'd0;
          end
          if (exec_size != 3'd0) begin
            if (tag == TAG_GLOBAL_LOG_MIN) begin
              st_nxt.glob_min = payload;
            end else if (tag == TAG_GLOBAL_LOG_MAX) begin
              st_nxt.glob_max = payload;
            end
          end
        end
        ITEM_LOCAL: begin
          if (tag == TAG_LOCAL_USAGE) begin
            st_nxt.local_usage = st_nxt.last_pay;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ design/hid_descriptor_range_extractor_unit.sv @@
// Top level of the HID report descriptor range extractor.
// The block takes one descriptor byte per clock cycle with no gaps of its own, and
// each byte updates the parser registers in the cycle it is accepted. The byte flagged
// last loads the result register, which shows the transaction on the next cycle, and
// returns the parser to its reset state so that the next descriptor can start at once.
// The input stalls only when a last byte arrives while the previous result is still
// held by a stalled output; all other bytes are taken in every cycle.
module hid_descriptor_range_extractor_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_desc_byte,
  input  logic              in_last_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_device_usage,
  output logic [31:0]       out_x_min,
  output logic [31:0]       out_x_max,
  output logic [31:0]       out_y_min,
  output logic [31:0]       out_y_max,
  output logic signed [7:0] out_tilt_x_min,
  output logic signed [7:0] out_tilt_x_max,
  output logic signed [7:0] out_tilt_y_min,
  output logic signed [7:0] out_tilt_y_max,
  output logic [31:0]       out_pressure_min,
  output logic [31:0]       out_pressure_max,
  output logic              out_truncated
);
  import hdre_pkg::*;

  parse_state_t st_r;
  parse_state_t st_nxt;
  ranges_t      res_r;
  logic         trunc_r;
  logic         out_valid_r;
  logic         in_fire;

  hdre_item_step u_step (
    .st        (st_r),
    .desc_byte (in_desc_byte),
    .st_nxt    (st_nxt)
  );

  assign in_stall = in_last_byte && out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r <= in_last_byte ? parse_state_t'('0) : st_nxt;
      end
      if (in_fire && in_last_byte) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_last_byte) begin
      res_r   <= st_nxt.ranges;
      trunc_r <= (st_nxt.pending != 3'd0);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_device_usage = res_r.usage;
  assign out_x_min        = res_r.x_min;
  assign out_x_max        = res_r.x_max;
  assign out_y_min        = res_r.y_min;
  assign out_y_max        = res_r.y_max;
  assign out_tilt_x_min   = $signed(res_r.tx_min);
  assign out_tilt_x_max   = $signed(res_r.tx_max);
  assign out_tilt_y_min   = $signed(res_r.ty_min);
  assign out_tilt_y_max   = $signed(res_r.ty_max);
  assign out_pressure_min = res_r.p_min;
  assign out_pressure_max = res_r.p_max;
  assign out_truncated    = trunc_r;

endmodule

@@ design/hdre_checker.sv @@
// Port-level assertions for the range extractor and the bind that attaches them.
module hdre_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic in_last_byte,
  input logic out_valid,
  input logic out_stall
);

  // A result that is stalled stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  // A new result follows only the transaction of a last byte.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_last_byte))
    else $error("result without a last byte");

  // A byte that is not last never produces a result.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_last_byte && !out_valid) |=> !out_valid)
    else $error("result after a byte that is not last");

  // The input stalls only for a last byte facing a full, stalled output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_last_byte && out_valid && out_stall))
    else $error("input stalled without cause");

endmodule

bind hid_descriptor_range_extractor_unit hdre_checker u_hdre_checker (.*);

@@ sim/tb.sv @@
// Self-checking testbench for the HID report descriptor range extractor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hdre_pkg::*;

  localparam logic [1:0] SIZE_0 = 2'd0;
  localparam logic [1:0] SIZE_1 = 2'd1;
  localparam logic [1:0] SIZE_2 = 2'd2;
  localparam logic [1:0] SIZE_4 = 2'd3;
  localparam logic [3:0] TAG_LONG_ITEM = 4'hF;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    ranges_t ranges;
    logic    truncated;
  } parsed_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_desc_byte = 8'h00;
  logic in_last_byte = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_device_usage;
  logic [31:0] out_x_min;
  logic [31:0] out_x_max;
  logic [31:0] out_y_min;
  logic [31:0] out_y_max;
  logic signed [7:0] out_tilt_x_min;
  logic signed [7:0] out_tilt_x_max;
  logic signed [7:0] out_tilt_y_min;
  logic signed [7:0] out_tilt_y_max;
  logic [31:0] out_pressure_min;
  logic [31:0] out_pressure_max;
  logic out_truncated;

  hid_descriptor_range_extractor_unit DUT (.*);

  always #2 clk = ~clk;

  int bytes_left;
  logic [7:0] pending_prefix;
  logic [31:0] assembled;
  logic [7:0] short_payload;
  logic [31:0] log_min, log_max, saved_min, saved_max;
  logic [3:0] nest_depth;
  logic [1:0] input_count;
  logic [7:0] usage_sel;
  ranges_t captured_ranges;

  parsed_report_t expected_reports[$];
  logic [7:0] descriptor_bytes[$];
  int failures = 0;
  int bytes_sent = 0;
  bit tx_idle_enabled = 1'b0;
  bit rx_idle_enabled = 1'b0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  function automatic int payload_bytes(input logic [1:0] code);
    return (1 << code) >> 1;
  endfunction

  function automatic logic [7:0] item_prefix(input logic [3:0] tag, input item_type_t kind,
                                             input logic [1:0] code);
    return {tag, kind, code};
  endfunction

  task automatic clear_parser();
    bytes_left = 0;
    pending_prefix = '0;
    assembled = '0;
    short_payload = '0;
    log_min = '0;
    log_max = '0;
    saved_min = '0;
    saved_max = '0;
    nest_depth = '0;
    input_count = '0;
    usage_sel = '0;
    captured_ranges = '0;
  endtask

  task automatic apply_short_item(input logic [31:0] payload);
    logic [3:0] tag;
    item_type_t kind;
    tag = pending_prefix[7:4];
    kind = item_type_t'(pending_prefix[3:2]);
    case (kind)
      ITEM_MAIN: begin
        if (tag == TAG_MAIN_DATA_IN) begin
          if (input_count == 2'd0) begin
            if (captured_ranges.x_max == '0) begin
              captured_ranges.x_max = log_max;
              captured_ranges.x_min = log_min;
            end
          end else if (input_count == 2'd1) begin
            if (captured_ranges.y_max == '0) begin
              captured_ranges.y_max = log_max;
              captured_ranges.y_min = log_min;
            end
          end else begin
            if (usage_sel == USAGE_TILT_X && captured_ranges.tx_max == '0) begin
              captured_ranges.tx_max = log_max[7:0];
              captured_ranges.tx_min = log_min[7:0];
            end
            if (usage_sel == USAGE_TILT_Y && captured_ranges.ty_max == '0) begin
              captured_ranges.ty_max = log_max[7:0];
              captured_ranges.ty_min = log_min[7:0];
            end
            if (usage_sel == USAGE_TIP_PRESSURE && captured_ranges.p_max == '0) begin
              captured_ranges.p_max = log_max;
              captured_ranges.p_min = log_min;
            end
          end
          if (input_count < 2'd2) input_count++;
        end else if (tag == TAG_MAIN_COLLECTION) begin
          if (nest_depth != MAX_NESTING) begin
            nest_depth++;
            saved_min = log_min;
            saved_max = log_max;
          end
        end else if (tag == TAG_MAIN_END_COLL) begin
          if (nest_depth != 4'd0) begin
            nest_depth--;
            log_min = saved_min;
            log_max = saved_max;
          end
        end
      end
      ITEM_GLOBAL: begin
        if (tag == TAG_GLOBAL_USAGE && captured_ranges.usage == '0) begin
          captured_ranges.usage = short_payload;
        end
        if (tag == TAG_GLOBAL_REPORT_ID) input_count = '0;
        if (payload_bytes(pending_prefix[1:0]) != 0) begin
          if (tag == TAG_GLOBAL_LOG_MIN) log_min = payload;
          else if (tag == TAG_GLOBAL_LOG_MAX) log_max = payload;
        end
      end
      ITEM_LOCAL: begin
        if (tag == TAG_LOCAL_USAGE) usage_sel = short_payload;
      end
      default: begin
      end
    endcase
  endtask

  task automatic track_descriptor_byte(input logic [7:0] value, input logic last);
    int nbytes;
    int slot;
    parsed_report_t report;
    if (bytes_left == 0) begin
      pending_prefix = value;
      assembled = '0;
      bytes_left = payload_bytes(value[1:0]);
      if (bytes_left == 0) apply_short_item('0);
    end else begin
      nbytes = payload_bytes(pending_prefix[1:0]);
      slot = (nbytes - bytes_left) & 3;
      assembled |= 32'(value) << (8 * slot);
      bytes_left--;
      if (bytes_left == 0) begin
        if (nbytes == 1) short_payload = value;
        apply_short_item(assembled);
      end
    end
    if (last) begin
      report.ranges = captured_ranges;
      report.truncated = (bytes_left != 0);
      expected_reports.push_back(report);
      clear_parser();
    end
  endtask

  task automatic send_byte(input logic [7:0] value, input logic last);
    if (tx_idle_enabled && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_desc_byte <= value;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    track_descriptor_byte(value, last);
  endtask

  task automatic send_descriptor();
    foreach (descriptor_bytes[i]) begin
      send_byte(descriptor_bytes[i], i == descriptor_bytes.size() - 1);
    end
    descriptor_bytes.delete();
  endtask

  task automatic add_item(input logic [7:0] prefix, input logic [31:0] value);
    descriptor_bytes.push_back(prefix);
    for (int k = 0; k < payload_bytes(prefix[1:0]); k++) begin
      descriptor_bytes.push_back(value[8*k +: 8]);
    end
  endtask

  task automatic add_truncated_item();
    logic [7:0] prefix;
    prefix = 8'($urandom);
    if (prefix[1:0] == SIZE_0) prefix[1:0] = SIZE_4;
    descriptor_bytes.push_back(prefix);
    repeat ($urandom_range(0, payload_bytes(prefix[1:0]) - 1)) begin
      descriptor_bytes.push_back(8'($urandom));
    end
  endtask

  function automatic logic [31:0] pick_range_value();
    case ($urandom_range(0, 6))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h0000_007F;
      4: return 32'h0000_0080;
      5: return 32'($urandom_range(1, 255));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_usage();
    logic [31:0] value;
    value = $urandom;
    case ($urandom_range(0, 4))
      0: value[7:0] = USAGE_TIP_PRESSURE;
      1: value[7:0] = USAGE_TILT_X;
      2: value[7:0] = USAGE_TILT_Y;
      default: begin
      end
    endcase
    return value;
  endfunction

  task automatic build_random_descriptor();
    logic [1:0] code;
    descriptor_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 24)) descriptor_bytes.push_back(8'($urandom));
      return;
    end
    repeat ($urandom_range(1, 14)) begin
      code = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 10))
        0: add_item(item_prefix(TAG_GLOBAL_USAGE, ITEM_GLOBAL, code), pick_usage());
        1, 2: begin
          if ($urandom_range(0, 3) != 0) code = SIZE_1;
          add_item(item_prefix(TAG_LOCAL_USAGE, ITEM_LOCAL, code), pick_usage());
        end
        3: add_item(item_prefix(TAG_GLOBAL_LOG_MIN, ITEM_GLOBAL, code), pick_range_value());
        4: add_item(item_prefix(TAG_GLOBAL_LOG_MAX, ITEM_GLOBAL, code), pick_range_value());
        5, 6: add_item(item_prefix(TAG_MAIN_DATA_IN, ITEM_MAIN, code), $urandom);
        7: begin
          repeat ($urandom_range(1, 12)) begin
            add_item(item_prefix(TAG_MAIN_COLLECTION, ITEM_MAIN, code), $urandom);
          end
        end
        8: begin
          repeat ($urandom_range(1, 12)) begin
            add_item(item_prefix(TAG_MAIN_END_COLL, ITEM_MAIN, code), $urandom);
          end
        end
        9: add_item(item_prefix(TAG_GLOBAL_REPORT_ID, ITEM_GLOBAL, code), $urandom);
        default: add_item(8'($urandom), $urandom);
      endcase
    end
    if ($urandom_range(0, 5) == 0) add_truncated_item();
  endtask

  task automatic check_field(input string name, input logic [31:0] expected,
                             input logic [31:0] actual);
    if (actual !== expected) begin
      $error("%s: expected %h, actual %h", name, expected, actual);
      failures++;
    end
  endtask

  task automatic check_report();
    parsed_report_t exp;
    if (expected_reports.size() == 0) begin
      $error("result transaction with no expected result pending");
      failures++;
      return;
    end
    exp = expected_reports.pop_front();
    check_field("device_usage", exp.ranges.usage, out_device_usage);
    check_field("x_min", exp.ranges.x_min, out_x_min);
    check_field("x_max", exp.ranges.x_max, out_x_max);
    check_field("y_min", exp.ranges.y_min, out_y_min);
    check_field("y_max", exp.ranges.y_max, out_y_max);
    check_field("tilt_x_min", exp.ranges.tx_min, unsigned'(out_tilt_x_min));
    check_field("tilt_x_max", exp.ranges.tx_max, unsigned'(out_tilt_x_max));
    check_field("tilt_y_min", exp.ranges.ty_min, unsigned'(out_tilt_y_min));
    check_field("tilt_y_max", exp.ranges.ty_max, unsigned'(out_tilt_y_max));
    check_field("pressure_min", exp.ranges.p_min, out_pressure_min);
    check_field("pressure_max", exp.ranges.p_max, out_pressure_max);
    check_field("truncated", exp.truncated, out_truncated);
  endtask

  always @(posedge clk) begin
    if (out_valid && !out_stall) check_report();
    if (hold_requests != holds_served) begin
      holds_served++;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (rx_idle_enabled && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic test_minimal_descriptors();
    add_item(item_prefix(TAG_MAIN_DATA_IN, ITEM_MAIN, SIZE_0), '0);
    send_descriptor();
    descriptor_bytes.push_back(item_prefix(TAG_LONG_ITEM, ITEM_RESERVED, SIZE_2));
    send_descriptor();
  endtask

  task automatic test_pen_ranges();
    add_item(item_prefix(TAG_GLOBAL_USAGE, ITEM_GLOBAL, SIZE_1), 32'h0D);
    add_item(item_prefix(TAG_GLOBAL_LOG_MIN, ITEM_GLOBAL, SIZE_1), 32'hC0);
    add_item(item_prefix(TAG_GLOBAL_LOG_MAX, ITEM_GLOBAL, SIZE_1), 32'h40);
    add_item(item_prefix(TAG_MAIN_DATA_IN, ITEM_MAIN, SIZE_0), '0);
    add_item(item_prefix(TAG_MAIN_DATA_IN, ITEM_MAIN, SIZE_0), '0);
    add_item(item_prefix(TAG_LOCAL_USAGE, ITEM_LOCAL, SIZE_1), USAGE_TIP_PRESSURE);
    add_item(item_prefix(TAG_MAIN_DATA_IN, ITEM_MAIN, SIZE_0), '0);
    add_item(item_prefix(TAG_LOCAL_USAGE, ITEM_LOCAL, SIZE_1), USAGE_TILT_X);
    add_item(item_prefix(TAG_MAIN_DATA_IN, ITEM_MAIN, SIZE_0), '0);
    add_item(item_prefix(TAG_LOCAL_USAGE, ITEM_LOCAL, SIZE_1), USAGE_TILT_Y);
    add_item(item_prefix(TAG_MAIN_DATA_IN, ITEM_MAIN, SIZE_0), '0);
    send_descriptor();
  endtask

  task automatic test_extremes_and_nesting();
    add_item(item_prefix(TAG_GLOBAL_LOG_MIN, ITEM_GLOBAL, SIZE_4), 32'h8000_0000);
    add_item(item_prefix(TAG_GLOBAL_LOG_MAX, ITEM_GLOBAL, SIZE_4), 32'hFFFF_FFFF);
    add_item(item_prefix(TAG_MAIN_COLLECTION, ITEM_MAIN, SIZE_0), '0);
    add_item(item_prefix(TAG_GLOBAL_LOG_MAX, ITEM_GLOBAL, SIZE_1), 32'h01);
    add_item(item_prefix(TAG_MAIN_END_COLL, ITEM_MAIN, SIZE_0), '0);
    add_item(item_prefix(TAG_MAIN_END_COLL, ITEM_MAIN, SIZE_0), '0);
    add_item(item_prefix(TAG_GLOBAL_REPORT_ID, ITEM_GLOBAL, SIZE_1), 32'hA5);
    add_item(item_prefix(TAG_MAIN_DATA_IN, ITEM_MAIN, SIZE_0), '0);
    add_item(item_prefix(TAG_GLOBAL_USAGE, ITEM_GLOBAL, SIZE_0), '0);
    descriptor_bytes.push_back(item_prefix(TAG_GLOBAL_LOG_MAX, ITEM_GLOBAL, SIZE_4));
    descriptor_bytes.push_back(8'h12);
    descriptor_bytes.push_back(8'h34);
    send_descriptor();
  endtask

  task automatic test_random_descriptors(input int byte_budget);
    int stop_at;
    stop_at = bytes_sent + byte_budget;
    while (bytes_sent < stop_at) begin
      build_random_descriptor();
      send_descriptor();
    end
  endtask

  task automatic test_output_backpressure();
    hold_requests++;
    repeat (8) begin
      add_item(item_prefix(TAG_GLOBAL_LOG_MAX, ITEM_GLOBAL, SIZE_1), pick_range_value());
      add_item(item_prefix(TAG_MAIN_DATA_IN, ITEM_MAIN, SIZE_0), '0);
      send_descriptor();
    end
  endtask

  initial begin
    clear_parser();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_minimal_descriptors();
    test_pen_ranges();
    test_extremes_and_nesting();
    tx_idle_enabled = 1'b1;
    rx_idle_enabled = 1'b1;
    test_random_descriptors(1000);
    test_output_backpressure();
    tx_idle_enabled = 1'b0;
    rx_idle_enabled = 1'b0;
    test_random_descriptors(300);
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
